[rtl/core/thumb16_instruction_decoder_assert.svh]
// Assertion macros for the Thumb decoder RTL.
// Depends on nothing; included inside the modules that check themselves.
`ifndef THUMB16_INSTRUCTION_DECODER_ASSERT_SVH
`define THUMB16_INSTRUCTION_DECODER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define T16_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("thumb16 decoder check failed");

// Next-cycle implication, checked out of reset.
`define T16_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("thumb16 decoder check failed");

`endif

[rtl/core/t16dec_pkg.sv]
// Shared types and codes for the Thumb 16-bit decoder.
// Used by t16dec_core and thumb16_instruction_decoder; no dependencies.
package t16dec_pkg;

    localparam int INSTR_W = 16;
    localparam int IMM_W   = 10;

    // format classes
    localparam logic [2:0] FMT_SHIFT_IMM = 3'd0;
    localparam logic [2:0] FMT_ADDSUB3   = 3'd1;
    localparam logic [2:0] FMT_IMM8      = 3'd2;
    localparam logic [2:0] FMT_ALU_REG   = 3'd3;
    localparam logic [2:0] FMT_HI_REG    = 3'd4;
    localparam logic [2:0] FMT_LDST_WB   = 3'd5;
    localparam logic [2:0] FMT_LDST_HALF = 3'd6;
    localparam logic [2:0] FMT_LDST_SP   = 3'd7;

    // top three opcode bits
    localparam logic [2:0] TOP_SHIFT_ADD = 3'd0;
    localparam logic [2:0] TOP_IMM8      = 3'd1;
    localparam logic [2:0] TOP_DATA      = 3'd2;
    localparam logic [2:0] TOP_LDST_WB   = 3'd3;
    localparam logic [2:0] TOP_LDST_HS   = 3'd4;

    // group selectors inside the data-processing space
    localparam logic [2:0] DP_ALU    = 3'd0;
    localparam logic [2:0] DP_HI_REG = 3'd1;

    localparam logic [1:0] SHIFT_LSL   = 2'd0;
    localparam logic [1:0] K_ADDSUB3   = 2'd3;
    localparam logic [3:0] ALU_RSB     = 4'd9;
    localparam logic [3:0] ALU_MUL     = 4'd13;
    localparam logic [1:0] HI_BX       = 2'd3;
    localparam logic [1:0] LDST_LDR    = 2'd1;
    localparam logic [3:0] REG_SP      = 4'd13;
    localparam logic [IMM_W-1:0] SHIFT_32 = IMM_W'(32);

    typedef struct packed {
        logic             valid_res;
        logic [2:0]       format;
        logic [3:0]       sub_op;
        logic [3:0]       reg_a;
        logic [3:0]       reg_b;
        logic [2:0]       reg_c;
        logic             has_reg_c;
        logic [IMM_W-1:0] imm;
        logic             has_imm;
    } t_dec_res;

endpackage

[rtl/core/thumb16_instruction_decoder.sv]
// Thumb 16-bit decoder, top level: request register, decode, result register.
// Depends on t16dec_pkg, t16dec_core and thumb16_instruction_decoder_assert.svh.
//
// One request per cycle: busy is always low, so a halfword is taken at every
// clock edge with start high. Its decode is on the result ports, with o_strobe
// high, for one cycle: the request register takes the halfword at acceptance,
// and the result register then takes its decode. The receiver cannot stall;
// results come out in request order, one per request. Undecoded encodings give
// o_valid_res low with every other field zero.
module thumb16_instruction_decoder
    import t16dec_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [INSTR_W-1:0] i_instruction,
    output logic               o_strobe,
    output logic               o_valid_res,
    output logic [2:0]         o_format,
    output logic [3:0]         o_sub_op,
    output logic [3:0]         o_reg_a,
    output logic [3:0]         o_reg_b,
    output logic [2:0]         o_reg_c,
    output logic               o_has_reg_c,
    output logic [IMM_W-1:0]   o_imm,
    output logic               o_has_imm
);

    logic [INSTR_W-1:0] r_instr;
    logic               r_in_vld;
    t_dec_res           n_res;
    t_dec_res           r_res;
    logic               r_out_vld;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= start && !busy;
            r_out_vld <= r_in_vld;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_instr <= i_instruction;
        end
        if (r_in_vld) begin
            r_res <= n_res;
        end
    end

    t16dec_core u_core (
        .i_instr (r_instr),
        .o_res   (n_res)
    );

    assign o_strobe    = r_out_vld;
    assign o_valid_res = r_res.valid_res;
    assign o_format    = r_res.format;
    assign o_sub_op    = r_res.sub_op;
    assign o_reg_a     = r_res.reg_a;
    assign o_reg_b     = r_res.reg_b;
    assign o_reg_c     = r_res.reg_c;
    assign o_has_reg_c = r_res.has_reg_c;
    assign o_imm       = r_res.imm;
    assign o_has_imm   = r_res.has_imm;

`include "thumb16_instruction_decoder_assert.svh"

    `T16_ASSERT_NEXT(a_req_to_result, i_clk, i_rst_n, start && !busy, ##1 o_strobe)
    `T16_ASSERT_NEXT(a_result_has_req, i_clk, i_rst_n, !r_in_vld, !o_strobe)
    `T16_ASSERT_NOW(a_invalid_zero, i_clk, i_rst_n, o_strobe && !o_valid_res,
        o_format == 3'd0 && o_sub_op == 4'd0 && o_reg_a == 4'd0 && o_reg_b == 4'd0 &&
        o_reg_c == 3'd0 && !o_has_reg_c && o_imm == '0 && !o_has_imm)
    `T16_ASSERT_NOW(a_reg_c_formats, i_clk, i_rst_n, o_strobe && o_has_reg_c,
        o_format == FMT_ADDSUB3 || o_format == FMT_ALU_REG)

endmodule

[rtl/core/t16dec_core.sv]
// Combinational decode of one Thumb halfword into a t_dec_res record.
// Depends on t16dec_pkg.
module t16dec_core
    import t16dec_pkg::*;
(
    input  logic [INSTR_W-1:0] i_instr,
    output t_dec_res           o_res
);

    logic [2:0] top3;
    logic [4:0] sh;

    assign top3 = i_instr[15:13];
    assign sh   = i_instr[10:6];

    always_comb begin
        o_res = '0;
        unique case (top3)
            TOP_SHIFT_ADD: begin
                o_res.valid_res = 1'b1;
                o_res.reg_a     = {1'b0, i_instr[2:0]};
                o_res.reg_b     = {1'b0, i_instr[5:3]};
                if (i_instr[12:11] == K_ADDSUB3) begin
                    o_res.format = FMT_ADDSUB3;
                    o_res.sub_op = {2'b00, i_instr[10:9]};
                    if (i_instr[10]) begin
                        o_res.imm     = {7'd0, i_instr[8:6]};
                        o_res.has_imm = 1'b1;
                    end else begin
                        o_res.reg_c     = i_instr[8:6];
                        o_res.has_reg_c = 1'b1;
                    end
                end else begin
                    o_res.format = FMT_SHIFT_IMM;
                    o_res.sub_op = {2'b00, i_instr[12:11]};
                    if (i_instr[12:11] == SHIFT_LSL) begin
                        // LSL #0 is MOVS
                        o_res.imm     = {5'd0, sh};
                        o_res.has_imm = (sh != 5'd0);
                    end else begin
                        // zero field encodes a shift of 32
                        o_res.imm     = (sh == 5'd0) ? SHIFT_32 : {5'd0, sh};
                        o_res.has_imm = 1'b1;
                    end
                end
            end
            TOP_IMM8: begin
                o_res.valid_res = 1'b1;
                o_res.format    = FMT_IMM8;
                o_res.sub_op    = {2'b00, i_instr[12:11]};
                o_res.reg_a     = {1'b0, i_instr[10:8]};
                o_res.imm       = {2'd0, i_instr[7:0]};
                o_res.has_imm   = 1'b1;
            end
            TOP_DATA: begin
                if (i_instr[12:10] == DP_ALU) begin
                    o_res.valid_res = 1'b1;
                    o_res.format    = FMT_ALU_REG;
                    o_res.sub_op    = i_instr[9:6];
                    o_res.reg_a     = {1'b0, i_instr[2:0]};
                    o_res.reg_b     = {1'b0, i_instr[5:3]};
                    if (i_instr[9:6] == ALU_RSB) begin
                        o_res.has_imm = 1'b1;
                    end else if (i_instr[9:6] == ALU_MUL) begin
                        o_res.reg_c     = i_instr[2:0];
                        o_res.has_reg_c = 1'b1;
                    end
                end else if (i_instr[12:10] == DP_HI_REG && i_instr[9:8] != HI_BX) begin
                    o_res.valid_res = 1'b1;
                    o_res.format    = FMT_HI_REG;
                    o_res.sub_op    = {2'b00, i_instr[9:8]};
                    o_res.reg_a     = {i_instr[7], i_instr[2:0]};
                    o_res.reg_b     = i_instr[6:3];
                end
            end
            TOP_LDST_WB: begin
                o_res.valid_res = 1'b1;
                o_res.format    = FMT_LDST_WB;
                o_res.sub_op    = {2'b00, i_instr[12:11]};
                o_res.reg_a     = {1'b0, i_instr[2:0]};
                o_res.reg_b     = {1'b0, i_instr[5:3]};
                // word forms scale by 4, byte forms do not
                o_res.imm       = (i_instr[12:11] <= LDST_LDR) ? {3'd0, sh, 2'b00}
                                                              : {5'd0, sh};
                o_res.has_imm   = 1'b1;
            end
            TOP_LDST_HS: begin
                o_res.valid_res = 1'b1;
                o_res.sub_op    = {3'b000, i_instr[11]};
                o_res.has_imm   = 1'b1;
                if (!i_instr[12]) begin
                    o_res.format = FMT_LDST_HALF;
                    o_res.reg_a  = {1'b0, i_instr[2:0]};
                    o_res.reg_b  = {1'b0, i_instr[5:3]};
                    o_res.imm    = {4'd0, sh, 1'b0};
                end else begin
                    o_res.format = FMT_LDST_SP;
                    o_res.reg_a  = {1'b0, i_instr[10:8]};
                    o_res.reg_b  = REG_SP;
                    o_res.imm    = {i_instr[7:0], 2'b00};
                end
            end
            default: begin
                o_res = '0;
            end
        endcase
    end

endmodule

[dv/testbench.sv]
// Self-checking testbench for thumb16_instruction_decoder: directed and random halfwords,
// each decode checked field by field against an in-bench prediction of the format decode.
// Depends on t16dec_pkg and the decoder RTL only.
`timescale 1ns / 1ps

module testbench;
    import t16dec_pkg::*;

    localparam int  RST_CYCLES   = 5;
    localparam int  RANDOM_ITEMS = 500;
    localparam int  TAIL_CYCLES  = 10;
    localparam int  CYCLE_LIMIT  = 200000;

    class decode_scoreboard;
        t_dec_res expected_q[$];
        int       errors;

        function new();
            errors = 0;
        endfunction

        function t_dec_res decode_halfword(logic [INSTR_W-1:0] x);
            t_dec_res r;
            r = '0;
            r.valid_res = 1'b1;
            case (x[15:13])
                TOP_SHIFT_ADD: begin
                    r.reg_a = {1'b0, x[2:0]};
                    r.reg_b = {1'b0, x[5:3]};
                    if (x[12:11] == K_ADDSUB3) begin
                        r.format = FMT_ADDSUB3;
                        r.sub_op = {2'b00, x[10:9]};
                        // bit 10 picks imm3 over Rm
                        if (x[10]) begin
                            r.imm     = IMM_W'(x[8:6]);
                            r.has_imm = 1'b1;
                        end else begin
                            r.reg_c     = x[8:6];
                            r.has_reg_c = 1'b1;
                        end
                    end else begin
                        r.format = FMT_SHIFT_IMM;
                        r.sub_op = {2'b00, x[12:11]};
                        if (x[12:11] == SHIFT_LSL) begin
                            // LSL #0 is a plain MOVS
                            r.imm     = IMM_W'(x[10:6]);
                            r.has_imm = (x[10:6] != 5'd0);
                        end else begin
                            // a zero field on LSR/ASR means a shift of 32
                            r.imm     = (x[10:6] == 5'd0) ? SHIFT_32 : IMM_W'(x[10:6]);
                            r.has_imm = 1'b1;
                        end
                    end
                end
                TOP_IMM8: begin
                    r.format  = FMT_IMM8;
                    r.sub_op  = {2'b00, x[12:11]};
                    r.reg_a   = {1'b0, x[10:8]};
                    r.imm     = IMM_W'(x[7:0]);
                    r.has_imm = 1'b1;
                end
                TOP_DATA: begin
                    case (x[12:10])
                        DP_ALU: begin
                            r.format = FMT_ALU_REG;
                            r.sub_op = x[9:6];
                            r.reg_a  = {1'b0, x[2:0]};
                            r.reg_b  = {1'b0, x[5:3]};
                            if (x[9:6] == ALU_RSB) begin
                                r.has_imm = 1'b1;
                            end else if (x[9:6] == ALU_MUL) begin
                                r.reg_c     = x[2:0];
                                r.has_reg_c = 1'b1;
                            end
                        end
                        DP_HI_REG: begin
                            r.format = FMT_HI_REG;
                            r.sub_op = {2'b00, x[9:8]};
                            r.reg_a  = {x[7], x[2:0]};
                            r.reg_b  = x[6:3];
                            if (x[9:8] == HI_BX) r.valid_res = 1'b0;
                        end
                        default: r.valid_res = 1'b0;
                    endcase
                end
                TOP_LDST_WB: begin
                    r.format  = FMT_LDST_WB;
                    r.sub_op  = {2'b00, x[12:11]};
                    r.reg_a   = {1'b0, x[2:0]};
                    r.reg_b   = {1'b0, x[5:3]};
                    r.has_imm = 1'b1;
                    // word forms scale by 4, byte forms do not
                    if (x[12:11] <= LDST_LDR) r.imm = IMM_W'(x[10:6]) << 2;
                    else                      r.imm = IMM_W'(x[10:6]);
                end
                TOP_LDST_HS: begin
                    r.sub_op  = {3'b000, x[11]};
                    r.has_imm = 1'b1;
                    if (!x[12]) begin
                        r.format = FMT_LDST_HALF;
                        r.reg_a  = {1'b0, x[2:0]};
                        r.reg_b  = {1'b0, x[5:3]};
                        r.imm    = IMM_W'(x[10:6]) << 1;
                    end else begin
                        r.format = FMT_LDST_SP;
                        r.reg_a  = {1'b0, x[10:8]};
                        r.reg_b  = REG_SP;
                        r.imm    = IMM_W'(x[7:0]) << 2;
                    end
                end
                default: r.valid_res = 1'b0;
            endcase
            if (!r.valid_res) r = '0;
            return r;
        endfunction

        function void note_request(logic [INSTR_W-1:0] x);
            expected_q.push_back(decode_halfword(x));
        endfunction

        function void compare_field(string name, int unsigned exp, int unsigned act);
            if (exp != act) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name, exp, act);
            end
        endfunction

        function void check_result(t_dec_res act);
            t_dec_res exp;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %h", $realtime, act);
                return;
            end
            exp = expected_q.pop_front();
            compare_field("valid_res", exp.valid_res, act.valid_res);
            compare_field("format",    exp.format,    act.format);
            compare_field("sub_op",    exp.sub_op,    act.sub_op);
            compare_field("reg_a",     exp.reg_a,     act.reg_a);
            compare_field("reg_b",     exp.reg_b,     act.reg_b);
            compare_field("reg_c",     exp.reg_c,     act.reg_c);
            compare_field("has_reg_c", exp.has_reg_c, act.has_reg_c);
            compare_field("imm",       exp.imm,       act.imm);
            compare_field("has_imm",   exp.has_imm,   act.has_imm);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [INSTR_W-1:0] i_instruction;
    logic               o_strobe;
    logic               o_valid_res;
    logic [2:0]         o_format;
    logic [3:0]         o_sub_op;
    logic [3:0]         o_reg_a;
    logic [3:0]         o_reg_b;
    logic [2:0]         o_reg_c;
    logic               o_has_reg_c;
    logic [IMM_W-1:0]   o_imm;
    logic               o_has_imm;

    decode_scoreboard sb = new();
    int               idle_pct;
    int               cycle_cnt;

    thumb16_instruction_decoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_instruction (i_instruction),
        .o_strobe      (o_strobe),
        .o_valid_res   (o_valid_res),
        .o_format      (o_format),
        .o_sub_op      (o_sub_op),
        .o_reg_a       (o_reg_a),
        .o_reg_b       (o_reg_b),
        .o_reg_c       (o_reg_c),
        .o_has_reg_c   (o_has_reg_c),
        .o_imm         (o_imm),
        .o_has_imm     (o_has_imm)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // note each accepted request first, then check whatever result ends this cycle
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) sb.note_request(i_instruction);
            if (o_strobe) begin
                sb.check_result('{o_valid_res, o_format, o_sub_op, o_reg_a, o_reg_b,
                                  o_reg_c, o_has_reg_c, o_imm, o_has_imm});
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("** thumb16_instruction_decoder: FAILED **");
            $finish;
        end
    end

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_halfword(input logic [INSTR_W-1:0] x);
        while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start         <= 1'b1;
        i_instruction <= x;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // hold off new requests until every decode is back
    task automatic drain_results();
        start <= 1'b0;
        while (sb.pending() > 0) @(negedge i_clk);
    endtask

    function automatic logic [INSTR_W-1:0] random_halfword();
        logic [INSTR_W-1:0] x;
        x = INSTR_W'($urandom_range(0, 65535));
        if ($urandom_range(0, 99) < 75) begin
            // aim at the decoded classes, with extra weight on ALU and hi-register groups
            x[15:13] = 3'($urandom_range(0, 4));
            if (x[15:13] == TOP_DATA && $urandom_range(0, 99) < 70)
                x[12:10] = $urandom_range(0, 1) ? DP_HI_REG : DP_ALU;
        end
        return x;
    endfunction

    logic [INSTR_W-1:0] directed_q[$] = '{
        16'h0000, 16'h07FF, 16'h0812, 16'h1000, 16'h17C9,
        16'h19D1, 16'h1BFF, 16'h1C00, 16'h1FFF,
        16'h20FF, 16'h2A00, 16'h3355, 16'h3FFF,
        16'h4000, 16'h4251, 16'h4363, 16'h43FF,
        16'h4400, 16'h45FF, 16'h46B4, 16'h47FF,
        16'h4800, 16'h6FFF, 16'h77C0, 16'h87FF,
        16'h8800, 16'h97FF, 16'h9800, 16'hA000, 16'hFFFF
    };

    initial begin
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_instruction = '0;
        cycle_cnt     = 0;
        idle_pct      = 24;
        repeat (RST_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_q[i]) send_halfword(directed_q[i]);
        drain_results();

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0:       idle_pct = 24;
                1:       idle_pct = 82;
                default: idle_pct = 0;
            endcase
            for (int n = 0; n < RANDOM_ITEMS / 3; n++) send_halfword(random_halfword());
            drain_results();
        end

        start <= 1'b0;
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (sb.pending() != 0) begin
            sb.errors++;
            $display("%0t: leftover decodes, expected 0, actual %0d", $realtime, sb.pending());
        end
        if (sb.errors == 0) begin
            $display("** thumb16_instruction_decoder: PASSED **");
        end else begin
            $display("** thumb16_instruction_decoder: FAILED **");
        end
        $finish;
    end

endmodule
